FILE: src/epoch_seconds_to_calendar_date_unit_macros.svh
// Assertion macros shared by the calendar date unit.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPSC_ASSERT_NOW(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("epsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPSC_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("epsc: next-cycle check failed");

`endif

FILE: src/epsc_pkg.sv
// Shared types, constants and microcode for the calendar date unit.
// Depends on nothing; used by the sequencer, datapath and top level.
package epsc_pkg;

    localparam int unsigned BASE_YEAR_VALUE = 2000;
    localparam int unsigned BASE_PRIOR      = BASE_YEAR_VALUE - 1;
    // Weekday of 1 January of the base year, Sunday = 0.
    localparam int unsigned JAN1_WEEKDAY    = (1 + 5 * (BASE_PRIOR % 4) + 4 * (BASE_PRIOR % 100)
                                               + 6 * (BASE_PRIOR % 400)) % 7;
    localparam int unsigned BASE_YR_IN_CENT = BASE_YEAR_VALUE % 100;
    localparam int unsigned BASE_CENT_MOD4  = (BASE_YEAR_VALUE / 100) % 4;

    // Reciprocals for constant division: q = (x * RECIP) >> SHIFT.
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int unsigned SHIFT_60 = 37;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam int unsigned SHIFT_24 = 36;
    localparam logic [31:0] RECIP_7  = 32'd74899;
    localparam int unsigned SHIFT_7  = 19;

    localparam logic [3:0] LAST_WALKED_MONTH = 4'd11;
    localparam logic [8:0] DAYS_LEAP_YEAR    = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR  = 9'd365;

    typedef enum logic [3:0] {
        OP_MUL60,
        OP_SPLIT_SEC,
        OP_SPLIT_MIN,
        OP_MUL24,
        OP_SPLIT_HOUR,
        OP_MUL7,
        OP_SPLIT_WDAY,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } op_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_FIRST = 4'd0;
    localparam step_t STEP_YEAR  = 4'd8;
    localparam step_t STEP_MONTH = 4'd9;
    localparam step_t STEP_COUNT = 4'd11;

    typedef struct packed {
        op_t   op;
        logic  jump_en;   // jump to target while the datapath condition holds
        step_t target;
        logic  last;
    } ctrl_word_t;

    typedef struct packed {
        logic load;       // capture a new transaction
        logic run;        // execute op this cycle
        op_t  op;
    } seq_ctrl_t;

    function automatic ctrl_word_t ucode_rom(step_t pc);
        ctrl_word_t w;
        w = '{op: OP_DONE, jump_en: 1'b0, target: STEP_FIRST, last: 1'b1};
        case (pc)
            4'd0:    w = '{op: OP_MUL60,      jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd1:    w = '{op: OP_SPLIT_SEC,  jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd2:    w = '{op: OP_MUL60,      jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd3:    w = '{op: OP_SPLIT_MIN,  jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd4:    w = '{op: OP_MUL24,      jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd5:    w = '{op: OP_SPLIT_HOUR, jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd6:    w = '{op: OP_MUL7,       jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd7:    w = '{op: OP_SPLIT_WDAY, jump_en: 1'b0, target: STEP_FIRST, last: 1'b0};
            4'd8:    w = '{op: OP_YEAR,       jump_en: 1'b1, target: STEP_YEAR,  last: 1'b0};
            4'd9:    w = '{op: OP_MONTH,      jump_en: 1'b1, target: STEP_MONTH, last: 1'b0};
            4'd10:   w = '{op: OP_DONE,       jump_en: 1'b0, target: STEP_FIRST, last: 1'b1};
            default: w = '{op: OP_DONE,       jump_en: 1'b0, target: STEP_FIRST, last: 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
        logic [4:0] d;
        case (month)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

FILE: src/epsc_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on epsc_pkg and the assertion macro header.
`include "epoch_seconds_to_calendar_date_unit_macros.svh"

module epsc_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cond,
    output logic                 busy,
    output logic                 done,
    output epsc_pkg::seq_ctrl_t  ctrl
);
    import epsc_pkg::*;

    step_t      pc_reg, pc_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    ctrl_word_t word;

    assign word      = ucode_rom(pc_reg);
    assign ctrl.load = start && !busy_reg;
    assign ctrl.run  = busy_reg;
    assign ctrl.op   = word.op;
    assign busy      = busy_reg;
    assign done      = done_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (word.jump_en && cond)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            pc_next   = STEP_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_FIRST;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    `EPSC_ASSERT_NOW(a_done_after_run, done_reg, $past(busy_reg) && !busy_reg)
    `EPSC_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `EPSC_ASSERT_NEXT(a_start_enters, start && !busy_reg, busy_reg && pc_reg == STEP_FIRST)
    `EPSC_ASSERT_NOW(a_pc_in_program, busy_reg, pc_reg < STEP_COUNT)

endmodule

FILE: src/epsc_datapath.sv
// Datapath: shared reciprocal multiplier, remainder logic, year and month walk.
// Depends on epsc_pkg.
module epsc_datapath (
    input  logic                 clk,
    input  epsc_pkg::seq_ctrl_t  ctrl,
    input  logic [31:0]          epoch_seconds,
    output logic                 cond,
    output logic [5:0]           second_of_minute,
    output logic [5:0]           minute_of_hour,
    output logic [4:0]           hour_of_day,
    output logic [2:0]           weekday,
    output logic [11:0]          calendar_year,
    output logic [3:0]           month_number,
    output logic [4:0]           day_in_month
);
    import epsc_pkg::*;

    logic [31:0] acc_reg;
    logic [63:0] prod_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;
    logic [2:0]  wd_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [6:0]  yr_in_cent_reg;
    logic [1:0]  cent_mod4_reg;
    logic [3:0]  month_reg;

    logic [31:0] mul_const;
    logic [31:0] q60, q24, q7;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_step;
    logic        month_step;

    always_comb
    begin
        case (ctrl.op)
            OP_MUL60: mul_const = RECIP_60;
            OP_MUL24: mul_const = RECIP_24;
            default:  mul_const = RECIP_7;
        endcase
    end

    assign q60 = 32'(prod_reg >> SHIFT_60);
    assign q24 = 32'(prod_reg >> SHIFT_24);
    assign q7  = 32'(prod_reg >> SHIFT_7);

    // Full Gregorian rule, tracked by year-in-century and century mod 4.
    assign leap = (year_reg[1:0] == 2'd0) && ((yr_in_cent_reg != 7'd0) || (cent_mod4_reg == 2'd0));
    assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mlen = month_days(month_reg, leap);

    assign year_step  = days_reg >= {7'd0, ylen};
    assign month_step = (month_reg < LAST_WALKED_MONTH) && (days_reg >= {11'd0, mlen});

    always_comb
    begin
        case (ctrl.op)
            OP_YEAR:  cond = year_step;
            OP_MONTH: cond = month_step;
            default:  cond = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg <= epoch_seconds;
        end
        else if (ctrl.run)
        begin
            case (ctrl.op)
                OP_MUL60,
                OP_MUL24,
                OP_MUL7:
                begin
                    prod_reg <= 64'(acc_reg) * 64'(mul_const);
                end
                OP_SPLIT_SEC:
                begin
                    sec_reg <= 6'(acc_reg - 32'(q60 * 32'd60));
                    acc_reg <= q60;
                end
                OP_SPLIT_MIN:
                begin
                    min_reg <= 6'(acc_reg - 32'(q60 * 32'd60));
                    acc_reg <= q60;
                end
                OP_SPLIT_HOUR:
                begin
                    hr_reg   <= 5'(acc_reg - 32'(q24 * 32'd24));
                    days_reg <= 16'(q24);
                    acc_reg  <= q24 + 32'(JAN1_WEEKDAY);
                end
                OP_SPLIT_WDAY:
                begin
                    wd_reg         <= 3'(acc_reg - 32'(q7 * 32'd7)) + 3'd1;
                    year_reg       <= 12'(BASE_YEAR_VALUE);
                    yr_in_cent_reg <= 7'(BASE_YR_IN_CENT);
                    cent_mod4_reg  <= 2'(BASE_CENT_MOD4);
                    month_reg      <= 4'd0;
                end
                OP_YEAR:
                begin
                    if (year_step)
                    begin
                        days_reg <= days_reg - {7'd0, ylen};
                        year_reg <= year_reg + 12'd1;
                        if (yr_in_cent_reg == 7'd99)
                        begin
                            yr_in_cent_reg <= 7'd0;
                            cent_mod4_reg  <= cent_mod4_reg + 2'd1;
                        end
                        else
                        begin
                            yr_in_cent_reg <= yr_in_cent_reg + 7'd1;
                        end
                    end
                end
                OP_MONTH:
                begin
                    if (month_step)
                    begin
                        days_reg  <= days_reg - {11'd0, mlen};
                        month_reg <= month_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign second_of_minute = sec_reg;
    assign minute_of_hour   = min_reg;
    assign hour_of_day      = hr_reg;
    assign weekday          = wd_reg;
    assign calendar_year    = year_reg;
    assign month_number     = month_reg + 4'd1;
    assign day_in_month     = days_reg[4:0] + 5'd1;

endmodule

FILE: src/epoch_seconds_to_calendar_date_unit.sv
// Top level of the epoch seconds to calendar date unit.
// Depends on epsc_pkg, epsc_sequencer and epsc_datapath.
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  request   | start / busy     | epoch_seconds
//  result    | done (strobe)    | second_of_minute, minute_of_hour, hour_of_day,
//            |                  | weekday, calendar_year, month_number,
//            |                  | day_in_month
//
// A transaction is taken at a clock edge with start high and busy low; busy then
// stays high until the result is ready. The unit walks the whole years past the
// base and then the months of the final year before the strobe done rises. The
// longest case walks 135 years and all eleven months. The year walk, one year per
// cycle in a single microcode step, sets the length of the longest conversion.
// A new transaction may be taken in the cycle that done is high.
// Reset clears the sequencer only; the result ports are not meaningful until the
// first done. The receiver cannot stall: each result is valid for the single
// cycle that done is high.
module epoch_seconds_to_calendar_date_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [2:0]  weekday,
    output logic [11:0] calendar_year,
    output logic [3:0]  month_number,
    output logic [4:0]  day_in_month
);
    import epsc_pkg::*;

    seq_ctrl_t ctrl;
    logic      cond;

    // Step through the microcode program; the datapath reports the jump
    // condition for the year and month walks.
    epsc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cond  (cond),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Hold the working values and the result fields; the fields stay put
    // between transactions.
    epsc_datapath u_dp (
        .clk              (clk),
        .ctrl             (ctrl),
        .epoch_seconds    (epoch_seconds),
        .cond             (cond),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .weekday          (weekday),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_in_month     (day_in_month)
    );

endmodule

FILE: verif/epsc_date_checker.sv
// Checker for the calendar date unit: predicts each result from the request
// channel and compares it with the done strobe. Depends on epsc_pkg for the base year.
module epsc_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] epoch_seconds,
    input  logic        done,
    input  logic [5:0]  second_of_minute,
    input  logic [5:0]  minute_of_hour,
    input  logic [4:0]  hour_of_day,
    input  logic [2:0]  weekday,
    input  logic [11:0] calendar_year,
    input  logic [3:0]  month_number,
    input  logic [4:0]  day_in_month,
    output int unsigned mismatch_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned START_YEAR = epsc_pkg::BASE_YEAR_VALUE;
    // 1 January 2000 fell on a Saturday (Sunday = 0).
    localparam int unsigned BASE_JAN1_DOW = 6;

    typedef struct {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [2:0]  weekday;
        logic [11:0] calendar_year;
        logic [3:0]  month_number;
        logic [4:0]  day_in_month;
    } calendar_fields_t;

    calendar_fields_t pending_dates[$];

    function automatic bit is_leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic calendar_fields_t split_epoch_seconds(logic [31:0] secs);
        calendar_fields_t f;
        int unsigned rest;
        int unsigned days;
        int unsigned year;
        int unsigned ylen;
        int unsigned mon;
        int unsigned mlen;
        rest = secs;
        f.second_of_minute = 6'(rest % 60);
        rest = rest / 60;
        f.minute_of_hour = 6'(rest % 60);
        rest = rest / 60;
        f.hour_of_day = 5'(rest % 24);
        days = rest / 24;
        f.weekday = 3'((days + BASE_JAN1_DOW) % 7 + 1);
        year = START_YEAR;
        ylen = is_leap_year(year) ? 366 : 365;
        while (days >= ylen) begin
            days = days - ylen;
            year++;
            ylen = is_leap_year(year) ? 366 : 365;
        end
        // December is never walked: whatever is left belongs to it.
        mon = 0;
        while (mon < 11) begin
            if (mon == 1)
                mlen = is_leap_year(year) ? 29 : 28;
            else if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
                mlen = 30;
            else
                mlen = 31;
            if (days < mlen)
                break;
            days = days - mlen;
            mon++;
        end
        f.calendar_year = 12'(year);
        f.month_number  = 4'(mon + 1);
        f.day_in_month  = 5'(days + 1);
        return f;
    endfunction

    task automatic check_field(string field, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // Retire the result first: a transaction taken in the done cycle is a new one.
    always @(posedge clk)
    begin
        calendar_fields_t exp_f;
        if (rst_n) begin
            if (done) begin
                if (pending_dates.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no transaction outstanding", $time);
                end else begin
                    exp_f = pending_dates.pop_front();
                    check_field("second_of_minute", exp_f.second_of_minute, second_of_minute);
                    check_field("minute_of_hour", exp_f.minute_of_hour, minute_of_hour);
                    check_field("hour_of_day", exp_f.hour_of_day, hour_of_day);
                    check_field("weekday", exp_f.weekday, weekday);
                    check_field("calendar_year", exp_f.calendar_year, calendar_year);
                    check_field("month_number", exp_f.month_number, month_number);
                    check_field("day_in_month", exp_f.day_in_month, day_in_month);
                end
            end
            if (start && !busy)
                pending_dates.push_back(split_epoch_seconds(epoch_seconds));
            pending_count = pending_dates.size();
        end
    end

endmodule

FILE: verif/tb_epoch_seconds_to_calendar_date_unit.sv
// Testbench top for epoch_seconds_to_calendar_date_unit: drives directed and
// random conversions and gives the verdict. Depends on epsc_date_checker and the RTL.
module tb_epoch_seconds_to_calendar_date_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Drain wait, longer than the slowest conversion.
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_PER_PHASE = 238;
    localparam int unsigned MAX_GAP = 170;
    // Largest whole day number that a 32-bit count of seconds reaches.
    localparam int unsigned LAST_DAY = 49710;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [31:0] epoch_seconds;
    logic        busy;
    logic        done;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [2:0]  weekday;
    logic [11:0] calendar_year;
    logic [3:0]  month_number;
    logic [4:0]  day_in_month;

    int unsigned mismatch_count;
    int unsigned pending_count;

    // Sender idle percentage per phase. The receiver cannot hold results off,
    // so the receiver-only phase runs without idling and the combined phase
    // keeps only the sender part.
    int unsigned idle_pct[4] = '{0, 50, 0, 37};

    // Calendar corners: unit rollovers, leap day of 2000, the 2000/2001 and
    // 2135/2136 year boundaries, 2001 and 2100 (not leap) end of February,
    // and bit patterns up to the largest count.
    logic [31:0] corner_seconds[22] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd5097599,    32'd5097600,    32'd5184000,    32'd31535999,
        32'd31622399,   32'd31622400,   32'd36719999,   32'd36720000,
        32'd3160857599, 32'd3160857600, 32'd4291747199, 32'd4291747200,
        32'hAAAA_AAAA,  32'hFFFF_FFFF
    };

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    epoch_seconds_to_calendar_date_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .weekday          (weekday),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_in_month     (day_in_month)
    );

    epsc_date_checker date_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .weekday          (weekday),
        .calendar_year    (calendar_year),
        .month_number     (month_number),
        .day_in_month     (day_in_month),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    // Present one request and hold it until the unit takes it, then drop start
    // for a random gap if this phase idles. Call right after a rising edge.
    // Without a gap, start stays high so back-to-back requests never glitch it.
    task automatic convert_seconds(input logic [31:0] secs, input int unsigned pct);
        start         <= 1'b1;
        epoch_seconds <= secs;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99, 0) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
        end
    endtask

    initial
    begin
        longint unsigned cand;
        int unsigned     kind;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        epoch_seconds <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_seconds[i])
            convert_seconds(corner_seconds[i], 0);

        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                kind = $urandom_range(9, 0);
                if (kind < 4) begin
                    cand = $urandom;
                end else if (kind < 8) begin
                    // Land on midnight, the second after it, the last second of a day
                    // or a random second of a random day, so month and year boundaries get hit often.
                    cand = 64'($urandom_range(LAST_DAY, 0)) * 64'd86400;
                    case ($urandom_range(3, 0))
                        0: cand = cand;
                        1: cand = cand + 64'd86399;
                        2: cand = cand + 64'd1;
                        default: cand = cand + 64'($urandom_range(86399, 0));
                    endcase
                    if (cand > 64'hFFFF_FFFF)
                        cand = $urandom;
                end else begin
                    // Early dates keep the year walk short.
                    cand = $urandom_range(32'd200_000_000, 0);
                end
                convert_seconds(cand[31:0], idle_pct[p]);
            end
        end

        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        // Let any stray strobe show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_epoch_seconds_to_calendar_date_unit passed");
        else
            $display("tb_epoch_seconds_to_calendar_date_unit failed");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("tb_epoch_seconds_to_calendar_date_unit failed");
        $finish;
    end

endmodule
